FILE: sv/prt_pkg.sv
// Package for the proximity reservation table: request, response and entry types,
// the request kind codes and the fixed field widths.
// No dependencies.
package prt_pkg;

  localparam int COORD_BITS      = 24;
  localparam int OWNER_BITS      = 32;
  localparam int RADIUS_BITS     = 21;
  localparam int DEFAULT_ENTRIES = 64;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(4096);
  // A squared distance below a 21-bit radius needs every axis magnitude below 2^11.
  localparam int MAG_BITS        = (RADIUS_BITS + 1) / 2;
  localparam int SQ_BITS         = 2 * MAG_BITS;
  localparam int SUM_BITS        = SQ_BITS + 2;

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_OCCUPY  = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_QUERY_X = 3'd4
  } prt_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } prt_state_e;

  typedef struct packed {
    logic [2:0]                   kind;
    logic [OWNER_BITS-1:0]        owner_id;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } prt_req_t;

  typedef struct packed {
    logic occupied;
    logic table_full;
  } prt_rsp_t;

  typedef struct packed {
    logic                         valid;
    logic [OWNER_BITS-1:0]        owner;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } prt_entry_t;

endpackage

FILE: sv/prt_cell.sv
// One storage cell of the reservation ring: holds one entry and takes its
// neighbor's entry on every shift. Depends on prt_pkg.
module prt_cell
  import prt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       set_valid_i,
  input  prt_entry_t ent_i,
  output prt_entry_t ent_o
);

  logic       valid_q;
  prt_entry_t data_q;

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= ent_i.valid;
    end else if (set_valid_i) begin
      valid_q <= 1'b1;
    end
  end

  // Owner and position move along with the valid bit.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= ent_i;
    end
  end

  always_comb begin
    ent_o       = data_q;
    ent_o.valid = valid_q;
  end

endmodule

FILE: sv/prt_dist.sv
// Pipelined squared-distance test between the head entry and the request point.
// Three stages: differences, squares, sum and compare. Depends on prt_pkg.
module prt_dist
  import prt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         count_i,
  input  logic signed [COORD_BITS-1:0] ex_i,
  input  logic signed [COORD_BITS-1:0] ey_i,
  input  logic signed [COORD_BITS-1:0] ez_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  input  logic [RADIUS_BITS-1:0]       radius_i,
  output logic                         hit_o
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic                 cnt1_q, cnt2_q, near_q;
  logic [SQ_BITS-1:0]   sqx_q, sqy_q, sqz_q;
  logic [DW-1:0]        mx, my, mz;
  logic                 near_d;
  logic [SUM_BITS-1:0]  sum;

  // Valid flags of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q <= 1'b0;
      cnt2_q <= 1'b0;
    end else begin
      cnt1_q <= count_i;
      cnt2_q <= cnt1_q;
    end
  end

  // Stage one: per-axis differences, one bit wider than a coordinate.
  always_ff @(posedge clk_i) begin
    dx_q <= DW'(ex_i) - DW'(px_i);
    dy_q <= DW'(ey_i) - DW'(py_i);
    dz_q <= DW'(ez_i) - DW'(pz_i);
  end

  // Stage two: magnitudes; any axis at or above 2^MAG_BITS can never match.
  always_comb begin
    mx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    my = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    mz = dz_q[DW-1] ? DW'(-dz_q) : DW'(dz_q);
    near_d = (mx[DW-1:MAG_BITS] == '0) && (my[DW-1:MAG_BITS] == '0) &&
             (mz[DW-1:MAG_BITS] == '0);
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d;
    sqx_q  <= mx[MAG_BITS-1:0] * mx[MAG_BITS-1:0];
    sqy_q  <= my[MAG_BITS-1:0] * my[MAG_BITS-1:0];
    sqz_q  <= mz[MAG_BITS-1:0] * mz[MAG_BITS-1:0];
  end

  // Stage three: sum of squares against the radius.
  assign sum   = SUM_BITS'(sqx_q) + SUM_BITS'(sqy_q) + SUM_BITS'(sqz_q);
  assign hit_o = cnt2_q && near_q && (sum < SUM_BITS'(radius_i));

endmodule

FILE: sv/proximity_reservation_table.sv
// A request is accepted while idle and then passes through the states SCAN, DRAIN and FIN;
// done_o strobes in FIN, and the next request is accepted the cycle after the strobe,
// so the block does not take a new request before it is through with the last one.
// A request's run is set by the ring of cells, which rotates the whole table once past
// the single distance and key unit, followed by a drain that empties its pipeline.
// Reset empties the table and sets the radius to 64 squared (4096); results cannot be stalled.
module proximity_reservation_table
  import prt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  prt_req_t               req_i,
  output logic                   done_o,
  output prt_rsp_t               rsp_o,
  input  logic                   cfg_we_i,
  input  logic [RADIUS_BITS-1:0] cfg_wdata_i
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  prt_state_e             state_q, state_d;
  prt_req_t               req_q;
  logic [IDX_W-1:0]       idx_q, free_idx_q;
  logic                   found_q, free_seen_q, drain_q;
  logic                   occ_q, full_q;
  logic [RADIUS_BITS-1:0] radius_q;
  prt_entry_t             ent [ENTRIES];
  prt_entry_t             head, head_mod;
  logic                   own_hit, take_free, counted, dist_hit, shift, set_free;
  logic                   is_query;
  logic                   accept;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign shift    = (state_q == ST_SCAN);
  assign is_query = (req_q.kind == KIND_QUERY) || (req_q.kind == KIND_QUERY_X);
  assign set_free = (state_q == ST_DRAIN) && !drain_q && (req_q.kind == KIND_OCCUPY) &&
                    !found_q && free_seen_q;

  // Ring of cells; cell 0 is the head, whose updated entry re-enters at the tail.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    prt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .set_valid_i(set_free && (free_idx_q == IDX_W'(k))),
      .ent_i      ((k == ENTRIES - 1) ? head_mod : ent[(k + 1) % ENTRIES]),
      .ent_o      (ent[k])
    );
  end

  assign head = ent[0];

  // Key match and the update applied to the head entry as it passes.
  always_comb begin
    head_mod  = head;
    own_hit   = head.valid && (head.owner == req_q.owner_id);
    take_free = !head.valid && !free_seen_q;
    counted   = 1'b0;
    unique case (req_q.kind)
      KIND_CLEAR: begin
        head_mod.valid = 1'b0;
      end
      KIND_OCCUPY: begin
        // A free slot gets the entry at once but stays invalid until the lap ends.
        if (own_hit || (take_free && !found_q)) begin
          head_mod.owner = req_q.owner_id;
          head_mod.x     = req_q.pos_x;
          head_mod.y     = req_q.pos_y;
          head_mod.z     = req_q.pos_z;
        end
      end
      KIND_RELEASE: begin
        if (own_hit) begin
          head_mod.valid = 1'b0;
        end
      end
      KIND_QUERY: begin
        counted = shift && head.valid;
      end
      KIND_QUERY_X: begin
        counted = shift && head.valid && !own_hit;
      end
      default: begin
      end
    endcase
  end

  prt_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (counted),
    .ex_i    (head.x),
    .ey_i    (head.y),
    .ez_i    (head.z),
    .px_i    (req_q.pos_x),
    .py_i    (req_q.pos_y),
    .pz_i    (req_q.pos_z),
    .radius_i(radius_q),
    .hit_o   (dist_hit)
  );

  // Sequencer: one lap of the ring, a short drain, then the result strobe.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (idx_q == IDX_W'(ENTRIES - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan bookkeeping and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_seen_q <= 1'b0;
      free_idx_q  <= '0;
      drain_q     <= 1'b0;
      occ_q       <= 1'b0;
      full_q      <= 1'b0;
    end else if (accept) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_seen_q <= 1'b0;
      drain_q     <= 1'b0;
      occ_q       <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IDX_W'(1);
        if (own_hit) begin
          found_q <= 1'b1;
        end
        if (take_free) begin
          free_seen_q <= 1'b1;
          free_idx_q  <= idx_q;
        end
      end
      if (state_q == ST_DRAIN) begin
        drain_q <= 1'b1;
        if (!drain_q && (req_q.kind == KIND_OCCUPY) && !found_q && !free_seen_q) begin
          full_q <= 1'b1;
        end
      end
      if (dist_hit) begin
        occ_q <= 1'b1;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign done_o           = (state_q == ST_FIN);
  assign rsp_o.occupied   = done_o && occ_q && is_query;
  assign rsp_o.table_full = done_o && full_q;

  // A finished request frees the block in the next cycle.
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result strobe");

  // An accepted request starts a lap.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (idx_q == '0)) else $error("lap did not start");

  // Only an occupy can report a full table, and never together with a hit.
  a_full_only_occupy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.table_full |-> (req_q.kind == KIND_OCCUPY) && !rsp_o.occupied)
    else $error("full flag on wrong request");

  // The distance unit only reports during a query lap or its drain.
  a_hit_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_hit |-> is_query && ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
    else $error("stray distance hit");

endmodule

FILE: tb/prt_checker.sv
// Checker for the proximity reservation table: mirrors the table, predicts each
// response and compares it against done_o/rsp_o. Depends on prt_pkg.
module prt_checker
  import prt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   busy,
  input  prt_req_t               req_i,
  input  logic                   done_o,
  input  prt_rsp_t               rsp_o,
  input  logic                   cfg_we_i,
  input  logic [RADIUS_BITS-1:0] cfg_wdata_i,
  output int                     fail_count,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the table and the radius register.
  logic                         mir_valid [ENTRIES];
  logic [OWNER_BITS-1:0]        mir_owner [ENTRIES];
  logic signed [COORD_BITS-1:0] mir_x [ENTRIES];
  logic signed [COORD_BITS-1:0] mir_y [ENTRIES];
  logic signed [COORD_BITS-1:0] mir_z [ENTRIES];
  logic [RADIUS_BITS-1:0]       mir_radius;
  prt_rsp_t                     rsp_queue [$];

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Exact squared distance; 25-bit differences squared fit easily in 64 bits.
  function automatic logic within_radius(input int idx, input prt_req_t r);
    longint dx, dy, dz;
    dx = longint'(mir_x[idx]) - longint'(r.pos_x);
    dy = longint'(mir_y[idx]) - longint'(r.pos_y);
    dz = longint'(mir_z[idx]) - longint'(r.pos_z);
    return (dx * dx + dy * dy + dz * dz) < longint'({1'b0, mir_radius});
  endfunction

  // Apply one request to the mirror and return the expected response.
  function automatic prt_rsp_t apply_request(input prt_req_t r);
    prt_rsp_t res;
    int hit, free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    case (r.kind)
      KIND_CLEAR: begin
        foreach (mir_valid[i]) mir_valid[i] = 1'b0;
      end
      KIND_OCCUPY: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (mir_valid[i]) begin
            if (hit < 0 && mir_owner[i] == r.owner_id) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit < 0) hit = free_slot;
        if (hit < 0) begin
          res.table_full = 1'b1;
        end else begin
          mir_valid[hit] = 1'b1;
          mir_owner[hit] = r.owner_id;
          mir_x[hit] = r.pos_x;
          mir_y[hit] = r.pos_y;
          mir_z[hit] = r.pos_z;
        end
      end
      KIND_RELEASE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (mir_valid[i] && mir_owner[i] == r.owner_id) mir_valid[i] = 1'b0;
      end
      KIND_QUERY, KIND_QUERY_X: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (mir_valid[i] && !(r.kind == KIND_QUERY_X && mir_owner[i] == r.owner_id)
              && within_radius(i, r)) begin
            res.occupied = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Watch request, config and response channels on each rising edge; reset clears the mirror.
  always @(posedge clk_i or negedge rst_ni) begin
    prt_rsp_t want;
    if (!rst_ni) begin
      foreach (mir_valid[i]) mir_valid[i] = 1'b0;
      mir_radius = RADIUS_RESET;
      rsp_queue.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (done_o) begin
        if (rsp_queue.size() == 0) begin
          report_mismatch("response with none expected");
        end else begin
          want = rsp_queue.pop_front();
          if (rsp_o.occupied !== want.occupied)
            report_mismatch($sformatf("occupied %b, expected %b", rsp_o.occupied,
                                      want.occupied));
          if (rsp_o.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, expected %b", rsp_o.table_full,
                                      want.table_full));
        end
      end
      if (cfg_we_i) mir_radius = cfg_wdata_i;
      if (start && !busy) rsp_queue.push_back(apply_request(req_i));
      pending_count = rsp_queue.size();
    end
  end
endmodule

FILE: tb/proximity_reservation_table_tb.sv
// Top of the proximity reservation table testbench: clock, reset and request
// stimulus with config phases. Depends on prt_pkg, prt_checker and the block.
module proximity_reservation_table_tb;
  import prt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = DEFAULT_ENTRIES;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  prt_req_t               req_i = '0;
  logic                   done_o;
  prt_rsp_t               rsp_o;
  logic                   cfg_we_i = 1'b0;
  logic [RADIUS_BITS-1:0] cfg_wdata_i = '0;
  int                     fail_count;
  int                     pending_count;
  logic [OWNER_BITS-1:0]  owner_pool [8];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  proximity_reservation_table #(.ENTRIES(ENTRIES)) dut (.*);

  prt_checker #(.ENTRIES(ENTRIES)) checker_inst (.*);

  // Send one request, holding start until it is taken.
  task automatic send_request(input logic [2:0] kind, input logic [OWNER_BITS-1:0] owner,
                              input int x, input int y, input int z);
    req_i.kind = kind;
    req_i.owner_id = owner;
    req_i.pos_x = x[COORD_BITS-1:0];
    req_i.pos_y = y[COORD_BITS-1:0];
    req_i.pos_z = z[COORD_BITS-1:0];
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Wait until every response is in, plus the block latency, then write radius.
  task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
    while (pending_count != 0) @(negedge clk_i);
    repeat (ENTRIES + 6) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'sh7FFFFF : -32'sh800000;
      1: return int'($urandom) >>> 8;
      default: return $urandom_range(0, 1024) - 512;
    endcase
  endfunction

  // Mostly near-cluster traffic over a small owner pool, some noise kinds.
  task automatic random_request();
    int sel, cx;
    logic [2:0] kind;
    sel = $urandom_range(0, 99);
    if (sel < 35) kind = KIND_OCCUPY;
    else if (sel < 50) kind = KIND_RELEASE;
    else if (sel < 72) kind = KIND_QUERY;
    else if (sel < 94) kind = KIND_QUERY_X;
    else if (sel < 96) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(5, 7));
    cx = rand_coord();
    send_request(kind, $urandom_range(0, 5) == 0 ? $urandom : owner_pool[$urandom_range(0, 7)],
                 cx, $urandom_range(0, 3) == 0 ? rand_coord() : cx / 2,
                 $urandom_range(0, 3) == 0 ? rand_coord() : 0);
  endtask

  initial begin
    foreach (owner_pool[i]) owner_pool[i] = $urandom;
    owner_pool[0] = '0;
    owner_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty query, extremes, update in place, release, unused kinds.
    send_request(KIND_QUERY, '0, 0, 0, 0);
    send_request(KIND_OCCUPY, '1, 32'sh7FFFFF, -32'sh800000, 32'sh7FFFFF);
    send_request(KIND_QUERY, '0, 32'sh7FFFFF, -32'sh800000, 32'sh7FFFFF);
    send_request(KIND_QUERY, '0, -32'sh800000, 32'sh7FFFFF, -32'sh800000);
    send_request(KIND_QUERY_X, '1, 32'sh7FFFFF, -32'sh800000, 32'sh7FFFFF);
    send_request(KIND_OCCUPY, '1, 10, 20, 30);
    send_request(KIND_QUERY, 5, 10 + 63, 20, 30);
    send_request(KIND_QUERY, 5, 10 + 64, 20, 30);
    send_request(KIND_RELEASE, 32'h1234, 0, 0, 0);
    send_request(KIND_RELEASE, '1, 0, 0, 0);
    send_request(KIND_QUERY, 5, 10, 20, 30);
    send_request(3'd5, '1, -1, -1, -1);
    send_request(3'd7, '0, 0, 0, 0);
    // Fill the table, then overflow, then update one in place.
    for (int i = 0; i < ENTRIES; i++) send_request(KIND_OCCUPY, i, i * 300, 0, 0);
    send_request(KIND_OCCUPY, 32'hDEAD_BEEF, 0, 0, 0);
    send_request(KIND_OCCUPY, 7, 1, 1, 1);
    send_request(KIND_CLEAR, '0, 0, 0, 0);
    send_request(KIND_QUERY, '0, 0, 0, 0);
    write_radius('0);
    send_request(KIND_OCCUPY, 3, 0, 0, 0);
    send_request(KIND_QUERY, 4, 0, 0, 0);
    write_radius(21'd1048576);
    send_request(KIND_QUERY, 4, 1023, 0, 0);
    send_request(KIND_QUERY, 4, 1024, 0, 0);

    // Random phases at several radii, bursts with random gaps.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_radius(RADIUS_RESET);
        1: write_radius('1);
        2: write_radius(21'($urandom));
        3: write_radius(21'd1);
        default: write_radius(21'($urandom_range(20000, 300000)));
      endcase
      for (int n = 0; n < 150; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 150; b++, n++) random_request();
        if (n == 75) while (pending_count != 0) @(negedge clk_i);
        else repeat ($urandom_range(0, 1) * $urandom_range(1, 80)) @(negedge clk_i);
      end
    end

    while (pending_count != 0) @(negedge clk_i);
    repeat (ENTRIES + 10) @(negedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(12ns * 400000);
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: proximity_reservation_table.f
sv/prt_pkg.sv
sv/prt_cell.sv
sv/prt_dist.sv
sv/proximity_reservation_table.sv
tb/prt_checker.sv
tb/proximity_reservation_table_tb.sv
